// ----- rtl/sha_pkg.sv -----
package sha_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       no_data;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       put;          // write put_byte at the current position
        logic [7:0] put_byte;
        logic       add_len;      // count eight more message bits
        logic       comp_start;   // load working registers from the chain
        logic       comp_round;   // run one round
        logic [5:0] round_idx;
        logic       comp_finish;  // fold working registers into the chain
        logic       msg_reset;    // back to the initial hash values
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0]  byte_pos;
        logic [63:0] bit_len;
    } dp_stat_t;

    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_if.sv -----
interface sha_in_if (input logic clk);
    logic               valid;
    logic               ready;
    sha_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if (input logic clk);
    logic               valid;
    logic               ready;
    sha_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/sha256_stream_hasher_top.sv -----
// SHA-256 over a byte stream. The 64th byte of a block starts a compression
// (one round per cycle in the shared round unit); no further byte is taken
// until it is through. At message end the controller writes the padding
// one byte per cycle and runs one or two more compressions, then presents
// the digest as four 64-bit words, h0 first.
// A request with no_data and is_last ends the message without a byte; on a
// fresh message it yields the digest of the empty string.
module sha256_stream_hasher_top (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    word_t    chain [8];

    sha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .stat   (stat),
        .chain  (chain),
        .cmd    (cmd)
    );

    sha_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .chain (chain)
    );

    a_no_reset_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !cmd.msg_reset)
        else $error("message state cleared with digest pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("digest dropped");
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.put, cmd.comp_start, cmd.comp_round, cmd.comp_finish}))
        else $error("conflicting datapath commands");
endmodule

// ----- rtl/sha_datapath.sv -----
module sha_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::dp_cmd_t cmd,
    output sha_pkg::dp_stat_t stat,
    output sha_pkg::word_t   chain [8]
);
    import sha_pkg::*;

    word_t       chain_reg [8];
    word_t       buf_reg [16];
    word_t       v_reg [8];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;

    word_t t1, t2, s0, s1, w_new, e, a;
    logic [1:0] lane;

    always_comb
    begin
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[cmd.round_idx] + buf_reg[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(buf_reg[1], 7) ^ rotr(buf_reg[1], 18) ^ (buf_reg[1] >> 3);
        s1 = rotr(buf_reg[14], 17) ^ rotr(buf_reg[14], 19) ^ (buf_reg[14] >> 10);
        w_new = buf_reg[0] + s0 + buf_reg[9] + s1;
        lane = pos_reg[1:0];
    end

    // The block buffer doubles as the message schedule: it shifts by one
    // word each round, so buf_reg[0] always holds the current w.
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            if (lane == 2'd0)
                buf_reg[pos_reg[5:2]] <= {cmd.put_byte, 24'd0};
            else
                buf_reg[pos_reg[5:2]][8*(3-lane) +: 8] <= cmd.put_byte;
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
                buf_reg[i] <= buf_reg[i+1];
            buf_reg[15] <= w_new;
        end
        if (cmd.comp_start)
            v_reg <= chain_reg;
        else if (cmd.comp_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= H_INIT;
            pos_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (cmd.msg_reset)
            begin
                chain_reg <= H_INIT;
                pos_reg <= '0;
                len_reg <= '0;
            end
            else
            begin
                if (cmd.comp_finish)
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                if (cmd.put)
                    pos_reg <= pos_reg + 6'd1;
                if (cmd.add_len)
                    len_reg <= len_reg + 64'd8;
            end
        end
    end

    assign stat.byte_pos = pos_reg;
    assign stat.bit_len = len_reg;
    assign chain = chain_reg;
endmodule

// ----- rtl/sha_ctrl.sv -----
module sha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    sha_in_if.sink            in_ch,
    sha_out_if.source         out_ch,
    input  sha_pkg::dp_stat_t stat,
    input  sha_pkg::word_t    chain [8],
    output sha_pkg::dp_cmd_t  cmd
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;     // message is being finished
    logic        padded_reg, padded_next;
    logic        wrap_reg, wrap_next;
    logic [63:0] len_reg, len_next;     // bit length, updated with each accepted request
    logic        ovalid_reg, ovalid_next;
    logic        last_len_reg;
    out_item_t   odata_reg;
    logic        take, accept;
    logic [7:0]  pad_byte;

    assign take = (state_reg == S_IDLE);
    assign in_ch.ready = take;
    assign accept = in_ch.valid && take;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = odata_reg;

    // When the pad byte lands inside the length field, the rest of that block
    // is zero and the length goes into one more block.
    always_comb
    begin
        if (!padded_reg)
            pad_byte = PAD_BYTE;
        else if (stat.byte_pos < LEN_POS || wrap_reg)
            pad_byte = 8'd0;
        else
            pad_byte = len_reg[{3'd7 - stat.byte_pos[2:0], 3'b000} +: 8];
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        padded_next = padded_reg;
        wrap_next = wrap_reg;
        len_next = len_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        cmd = '0;
        cmd.round_idx = rnd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.put = !in_ch.payload.no_data;
                    cmd.put_byte = in_ch.payload.data_byte;
                    cmd.add_len = !in_ch.payload.no_data;
                    fin_next = in_ch.payload.is_last;
                    padded_next = 1'b0;
                    wrap_next = 1'b0;
                    len_next = stat.bit_len + (in_ch.payload.no_data ? 64'd0 : 64'd8);
                    if (!in_ch.payload.no_data && stat.byte_pos == 6'd63)
                        state_next = S_START;
                    else if (in_ch.payload.is_last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.put = 1'b1;
                cmd.put_byte = pad_byte;
                padded_next = 1'b1;
                if (!padded_reg)
                    wrap_next = (stat.byte_pos >= LEN_POS);
                if (stat.byte_pos == 6'd63)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.comp_start = 1'b1;
                rnd_next = '0;
                wrap_next = 1'b0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.comp_round = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.comp_finish = 1'b1;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (last_len_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_PAD;
            end
            S_EMIT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    cmd.msg_reset = 1'b1;
                    fin_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // A padded block that fills ends the message only when its last byte
    // was the final length byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_len_reg <= 1'b0;
        else if (state_reg == S_PAD)
            last_len_reg <= padded_reg && !wrap_reg && stat.byte_pos == 6'd63;
        else if (state_reg == S_IDLE)
            last_len_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && !ovalid_reg)
        begin
            odata_reg.digest_word0 <= {chain[0], chain[1]};
            odata_reg.digest_word1 <= {chain[2], chain[3]};
            odata_reg.digest_word2 <= {chain[4], chain[5]};
            odata_reg.digest_word3 <= {chain[6], chain[7]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            padded_reg <= 1'b0;
            wrap_reg <= 1'b0;
            len_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            fin_reg <= fin_next;
            padded_reg <= padded_next;
            wrap_reg <= wrap_next;
            len_reg <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

// ----- tb/tb_sha256_stream_hasher_top.sv -----
module tb_sha256_stream_hasher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 1650;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch (clk);
    sha_out_if out_ch (clk);

    sha256_stream_hasher_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predictor state: chaining words, block bytes, byte position, bit length.
    word_t       chain [8];
    logic [7:0]  blk_bytes [64];
    int          blk_pos;
    logic [63:0] msg_bits;

    out_item_t digest_queue [$];

    int mismatches;
    int digests_seen;
    int requests_sent;
    int idle_cycles;
    bit timed_out;

    function automatic word_t ror32(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_block();
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] += v[i];
        end
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        blk_bytes[blk_pos] = b;
        blk_pos++;
        if (blk_pos == 64)
        begin
            hash_block();
            blk_pos = 0;
        end
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = H_INIT[i];
        end
        blk_pos  = 0;
        msg_bits = '0;
    endfunction

    // Advances the predictor by one request; returns 1 with the digest when the message ends.
    function automatic bit predict_digest(in_item_t req, output out_item_t dig);
        logic [63:0] len;
        dig = '0;
        if (!req.no_data)
        begin
            absorb_byte(req.data_byte);
            msg_bits += 64'd8;
        end
        if (!req.is_last)
        begin
            return 1'b0;
        end
        len = msg_bits;
        absorb_byte(PAD_BYTE);
        while (blk_pos != int'(LEN_POS))
        begin
            absorb_byte(8'h00);
        end
        for (int s = 56; s >= 0; s -= 8)
        begin
            absorb_byte(len[s +: 8]);
        end
        dig.digest_word0 = {chain[0], chain[1]};
        dig.digest_word1 = {chain[2], chain[3]};
        dig.digest_word2 = {chain[4], chain[5]};
        dig.digest_word3 = {chain[6], chain[7]};
        restart_message();
        return 1'b1;
    endfunction

    function automatic void expect_digest(out_item_t d);
        digest_queue = {digest_queue, d};
    endfunction

    // Directed table. Known digests are typed in for the empty message and "abc".
    typedef struct {
        in_item_t  req;
        bit        has_known;
        out_item_t known;
    } directed_row_t;

    localparam out_item_t DIGEST_EMPTY = '{
        64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
        64'h27ae41e4649b934c, 64'ha495991b7852b855};
    localparam out_item_t DIGEST_ABC = '{
        64'hba7816bf8f01cfea, 64'h414140de5dae2223,
        64'hb00361a396177a9c, 64'hb410ff61f20015ad};

    directed_row_t directed_rows [$];

    function automatic void add_row(directed_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    function automatic directed_row_t mk_row(logic [7:0] b, logic last, logic none);
        directed_row_t r;
        r.req.data_byte = b;
        r.req.is_last   = last;
        r.req.no_data   = none;
        r.has_known     = 1'b0;
        r.known         = '0;
        return r;
    endfunction

    task automatic build_directed();
        directed_row_t r;
        // Empty message right after reset.
        r = mk_row(8'h00, 1'b1, 1'b1);
        r.has_known = 1'b1;
        r.known = DIGEST_EMPTY;
        add_row(r);
        // An item with neither byte nor end mark does nothing.
        add_row(mk_row(8'hff, 1'b0, 1'b1));
        add_row(mk_row(8'h61, 1'b0, 1'b0));
        add_row(mk_row(8'h62, 1'b0, 1'b0));
        r = mk_row(8'h63, 1'b1, 1'b0);
        r.has_known = 1'b1;
        r.known = DIGEST_ABC;
        add_row(r);
        // Empty message again, this time after a digest.
        r = mk_row(8'h5a, 1'b1, 1'b1);
        r.has_known = 1'b1;
        r.known = DIGEST_EMPTY;
        add_row(r);
        // Extreme byte values, then an end mark without a byte after bytes.
        add_row(mk_row(8'h00, 1'b0, 1'b0));
        add_row(mk_row(8'hff, 1'b0, 1'b0));
        add_row(mk_row(8'h00, 1'b1, 1'b1));
        // Single-byte messages, each with an end mark.
        add_row(mk_row(8'hff, 1'b1, 1'b0));
        add_row(mk_row(8'h80, 1'b1, 1'b0));
        add_row(mk_row(8'h01, 1'b1, 1'b0));
    endtask

    // Request driver with bursts and gaps.
    task automatic send_request(in_item_t req);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= req;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    int burst_left;

    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 80);
        end
    endtask

    task automatic issue(in_item_t req);
        out_item_t dig;
        pace_sender();
        if (predict_digest(req, dig))
        begin
            expect_digest(dig);
        end
        send_request(req);
    endtask

    // Random message lengths: mostly short, some around block boundaries, a few long.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return $urandom_range(0, 20);
        end
        else if (sel < 9)
        begin
            return $urandom_range(52, 70) + 64 * $urandom_range(0, 1);
        end
        return $urandom_range(100, 200);
    endfunction

    task automatic run_random();
        in_item_t req;
        int len;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = pick_length();
            for (int i = 0; i < len; i++)
            begin
                req.data_byte = 8'($urandom);
                req.no_data   = ($urandom_range(0, 15) == 0);
                req.is_last   = 1'b0;
                if (req.no_data)
                begin
                    req.data_byte = 8'($urandom);
                end
                issue(req);
                sent++;
            end
            req.data_byte = 8'($urandom);
            req.no_data   = ($urandom_range(0, 3) == 0);
            req.is_last   = 1'b1;
            issue(req);
            sent++;
        end
    endtask

    // Receiver stall pattern: alternating ready windows and stall windows.
    int stall_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_count  <= 0;
        end
        else if (stall_count > 0)
        begin
            stall_count <= stall_count - 1;
        end
        else
        begin
            out_ch.ready <= ~out_ch.ready;
            stall_count  <= out_ch.ready ? $urandom_range(0, 6) : $urandom_range(0, 30);
        end
    end

    // Digest checker.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            out_item_t want;
            digests_seen <= digests_seen + 1;
            if (digest_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected digest %h", out_ch.payload);
                end
            end
            else
            begin
                want = digest_queue.pop_front();
                if (out_ch.payload !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Digest mismatch: expected %h %h %h %h, got %h %h %h %h",
                            want.digest_word0, want.digest_word1,
                            want.digest_word2, want.digest_word3,
                            out_ch.payload.digest_word0, out_ch.payload.digest_word1,
                            out_ch.payload.digest_word2, out_ch.payload.digest_word3);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Watchdog expired with %0d digests outstanding", digest_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatches    = 0;
        digests_seen  = 0;
        requests_sent = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        burst_left    = 0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        restart_message();
        for (int i = 0; i < 64; i++)
        begin
            blk_bytes[i] = 8'h00;
        end
        build_directed();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            out_item_t dig;
            pace_sender();
            if (predict_digest(directed_rows[i].req, dig))
            begin
                if (directed_rows[i].has_known && dig !== directed_rows[i].known)
                begin
                    $display("Predictor disagrees with known digest in row %0d", i);
                    mismatches++;
                end
                expect_digest(directed_rows[i].has_known ? directed_rows[i].known : dig);
            end
            send_request(directed_rows[i].req);
        end

        run_random();
        in_ch.valid <= 1'b0;

        while (digest_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d digests, including block-boundary",
            requests_sent, digests_seen);
        $display("lengths, empty messages and byte-less end marks; %0d mismatches.", mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
